// ===== design/ffill_pkg.sv =====
// ffill_pkg: shared types, codes and defaults of the 4-connected flood fill block
// no dependencies; imported by every module of the block but ffill_ram
`timescale 1ns / 1ps

package ffill_pkg;

    // default geometry and colour depth
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_COLOR_BITS = 16;

    // item field widths
    localparam int COORD_BITS = 8;
    localparam int PIXEL_BITS = 16;
    localparam int COUNT_BITS = 17;

    // effective image size, wide enough for the largest supported image
    localparam int SIZE_BITS = 13;

    // configuration registers
    localparam int              REG_BITS       = 9;
    localparam logic [REG_BITS-1:0] REG_SIZE_RESET = 9'd256;
    localparam int              APB_ADDR_BITS  = 3;
    localparam int              APB_DATA_BITS  = 32;
    localparam logic            REG_IMAGE_WIDTH  = 1'b0;
    localparam logic            REG_IMAGE_HEIGHT = 1'b1;

    // command codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // effective image size handed from the register file to the sequencer
    typedef struct packed {
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
    } size_cfg_t;

endpackage

// ===== design/ffill_ram.sv =====
// ffill_ram: simple dual-port synchronous ram, one write and one registered read port
// depends on nothing; used for the pixel store and the coordinate queue
`timescale 1ns / 1ps

module ffill_ram #(
    parameter int DATA_BITS = 16,
    parameter int DEPTH     = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ffill_cfg.sv =====
// ffill_cfg: apb register file for the image width and height
// depends on ffill_pkg; presents the clamped image size to the sequencer
`timescale 1ns / 1ps

module ffill_cfg import ffill_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output size_cfg_t                sizes
);

    logic [REG_BITS-1:0] width_reg;
    logic [REG_BITS-1:0] height_reg;
    logic                reg_sel;
    logic                wr_en;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [SIZE_BITS-1:0] clamp_size(logic [REG_BITS-1:0] v,
                                                        logic [SIZE_BITS-1:0] maxv);
        logic [SIZE_BITS-1:0] ext;
        ext = SIZE_BITS'(v);
        if (ext == '0) begin
            return SIZE_BITS'(1);
        end else if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

    assign reg_sel = paddr[APB_ADDR_BITS-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= REG_SIZE_RESET;
            height_reg <= REG_SIZE_RESET;
        end else if (wr_en) begin
            if (reg_sel == REG_IMAGE_WIDTH) begin
                width_reg <= pwdata[REG_BITS-1:0];
            end else begin
                height_reg <= pwdata[REG_BITS-1:0];
            end
        end
    end

    // read back
    assign prdata = (reg_sel == REG_IMAGE_HEIGHT) ? APB_DATA_BITS'(height_reg)
                                                  : APB_DATA_BITS'(width_reg);

    // clamped size
    assign sizes.width  = clamp_size(width_reg, SIZE_BITS'(MAX_WIDTH));
    assign sizes.height = clamp_size(height_reg, SIZE_BITS'(MAX_HEIGHT));

endmodule

// ===== design/ffill_ctrl.sv =====
// ffill_ctrl: command sequencer with the breadth-first fill walk and the result register
// depends on ffill_pkg; drives the pixel store ram and the coordinate queue ram
`timescale 1ns / 1ps

module ffill_ctrl import ffill_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  size_cfg_t                                   sizes,
    // command item
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [1:0]                                  opcode,
    input  logic [COORD_BITS-1:0]                       x_coord,
    input  logic [COORD_BITS-1:0]                       y_coord,
    input  logic [PIXEL_BITS-1:0]                       pixel_color,
    // result item
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [PIXEL_BITS-1:0]                       read_color,
    output logic [COUNT_BITS-1:0]                       filled_count,
    output logic                                        coord_error,
    // pixel store
    output logic                                        pix_wr_en,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     pix_wr_addr,
    output logic [COLOR_BITS-1:0]                       pix_wr_data,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     pix_rd_addr,
    input  logic [COLOR_BITS-1:0]                       pix_rd_data,
    // coordinate queue
    output logic                                        q_wr_en,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     q_wr_addr,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_wr_data,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     q_rd_addr,
    input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_rd_data
);

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam int PW   = $clog2(NPIX + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);

    // neighbour visiting order
    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_UP    = 2'd1;
    localparam logic [1:0] NB_RIGHT = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SEED,
        S_POP,
        S_LOAD,
        S_NB,
        S_CHK
    } state_t;

    state_t                state_reg, state_next;
    logic [XW-1:0]         cur_x_reg, cur_x_next;
    logic [YW-1:0]         cur_y_reg, cur_y_next;
    logic [XW-1:0]         probe_x_reg, probe_x_next;
    logic [YW-1:0]         probe_y_reg, probe_y_next;
    logic [1:0]            nb_reg, nb_next;
    logic [COLOR_BITS-1:0] fill_color_reg, fill_color_next;
    logic [COLOR_BITS-1:0] target_reg, target_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PIXEL_BITS-1:0] rd_color_reg, rd_color_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  err_reg, err_next;

    logic                  accept;
    logic                  in_err;
    logic [XW-1:0]         in_x;
    logic [YW-1:0]         in_y;
    logic [AW-1:0]         in_addr;
    logic [31:0]           in_color_ext;
    logic [COLOR_BITS-1:0] in_color;
    logic [31:0]           rd_color_ext;
    logic [PW+COUNT_BITS-1:0] count_ext;
    logic                  nb_ok;
    logic [XW-1:0]         nb_x;
    logic [YW-1:0]         nb_y;
    logic [AW-1:0]         nb_addr;
    logic [AW-1:0]         probe_addr;

    // linear store index of a pixel
    function automatic logic [AW-1:0] pix_addr(logic [XW-1:0] px, logic [YW-1:0] py);
        return AW'(AW'(py) * AW'(MAX_WIDTH)) + AW'(px);
    endfunction

    // command decode
    assign s_tready     = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept       = s_tvalid && s_tready;
    assign in_err       = (SIZE_BITS'(x_coord) >= sizes.width) ||
                          (SIZE_BITS'(y_coord) >= sizes.height);
    assign in_x         = XW'(x_coord);
    assign in_y         = YW'(y_coord);
    assign in_addr      = pix_addr(in_x, in_y);
    assign in_color_ext = 32'(pixel_color);
    assign in_color     = in_color_ext[COLOR_BITS-1:0];
    assign rd_color_ext = 32'(pix_rd_data);
    assign count_ext    = (PW + COUNT_BITS)'(wr_ptr_reg);
    assign probe_addr   = pix_addr(probe_x_reg, probe_y_reg);
    assign nb_addr      = pix_addr(nb_x, nb_y);
    assign q_rd_addr    = rd_ptr_reg[AW-1:0];

    // neighbour of the current pixel and its bounds check
    always_comb begin
        nb_x = cur_x_reg;
        nb_y = cur_y_reg;
        unique case (nb_reg)
            NB_LEFT: begin
                nb_ok = (cur_x_reg != '0);
                nb_x  = cur_x_reg - 1'b1;
            end
            NB_UP: begin
                nb_ok = (cur_y_reg != '0);
                nb_y  = cur_y_reg - 1'b1;
            end
            NB_RIGHT: begin
                nb_ok = (SIZE_BITS'(cur_x_reg) + SIZE_BITS'(1)) < sizes.width;
                nb_x  = cur_x_reg + 1'b1;
            end
            NB_DOWN: begin
                nb_ok = (SIZE_BITS'(cur_y_reg) + SIZE_BITS'(1)) < sizes.height;
                nb_y  = cur_y_reg + 1'b1;
            end
        endcase
    end

    // sequencer next state and memory control
    always_comb begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        probe_x_next    = probe_x_reg;
        probe_y_next    = probe_y_reg;
        nb_next         = nb_reg;
        fill_color_next = fill_color_reg;
        target_next     = target_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_color_next   = rd_color_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;

        pix_wr_en   = 1'b0;
        pix_wr_addr = probe_addr;
        pix_wr_data = fill_color_reg;
        pix_rd_addr = in_addr;
        q_wr_en     = 1'b0;
        q_wr_addr   = wr_ptr_reg[AW-1:0];
        q_wr_data   = {probe_y_reg, probe_x_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    rd_color_next = '0;
                    count_next    = '0;
                    err_next      = 1'b0;
                    unique case (opcode)
                        OP_WRITE: begin
                            pix_wr_en    = !in_err;
                            pix_wr_addr  = in_addr;
                            pix_wr_data  = in_color;
                            err_next     = in_err;
                            m_valid_next = 1'b1;
                        end
                        OP_READ: begin
                            if (in_err) begin
                                err_next     = 1'b1;
                                m_valid_next = 1'b1;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        OP_FILL: begin
                            if (in_err) begin
                                err_next     = 1'b1;
                                m_valid_next = 1'b1;
                            end else begin
                                probe_x_next    = in_x;
                                probe_y_next    = in_y;
                                fill_color_next = in_color;
                                rd_ptr_next     = '0;
                                state_next      = S_SEED;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            // read data is back
            S_RD: begin
                rd_color_next = rd_color_ext[PIXEL_BITS-1:0];
                m_valid_next  = 1'b1;
                state_next    = S_IDLE;
            end
            // seed colour is back: stop at once or recolour and queue the seed
            S_SEED: begin
                target_next = pix_rd_data;
                if (pix_rd_data == fill_color_reg) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    pix_wr_en   = 1'b1;
                    q_wr_en     = 1'b1;
                    q_wr_addr   = '0;
                    wr_ptr_next = PW'(1);
                    state_next  = S_POP;
                end
            end
            // take the next queued pixel or finish
            S_POP: begin
                if (rd_ptr_reg == wr_ptr_reg) begin
                    count_next   = count_ext[COUNT_BITS-1:0];
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD: begin
                cur_x_next = q_rd_data[XW-1:0];
                cur_y_next = q_rd_data[XW+YW-1:XW];
                nb_next    = NB_LEFT;
                state_next = S_NB;
            end
            // read the next in-bounds neighbour
            S_NB: begin
                if (nb_ok) begin
                    pix_rd_addr  = nb_addr;
                    probe_x_next = nb_x;
                    probe_y_next = nb_y;
                    state_next   = S_CHK;
                end else if (nb_reg == NB_DOWN) begin
                    state_next = S_POP;
                end else begin
                    nb_next = nb_reg + 1'b1;
                end
            end
            // neighbour of the target colour: recolour it and queue it
            S_CHK: begin
                if (pix_rd_data == target_reg) begin
                    pix_wr_en   = 1'b1;
                    q_wr_en     = 1'b1;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (nb_reg == NB_DOWN) begin
                    state_next = S_POP;
                end else begin
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_NB;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            probe_x_reg    <= probe_x_next;
            probe_y_reg    <= probe_y_next;
            nb_reg         <= nb_next;
            fill_color_reg <= fill_color_next;
            target_reg     <= target_next;
            rd_color_reg   <= rd_color_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign read_color   = rd_color_reg;
    assign filled_count = count_reg;
    assign coord_error  = err_reg;

endmodule

// ===== design/flood_fill_4conn.sv =====
// flood_fill_4conn: pixel store with write, read and 4-connected flood fill commands
// timing: a fill takes longer with every filled pixel and every neighbour probed, and stops at the
// seed if the seed already has the new colour; set by the one read port of the pixel store and
// its registered read
// throughput: one command at a time; a waiting result holds off the next until it is taken
// reset: synchronous active-low aresetn; sizes return to 256, pixel store not reset, queue empty
`timescale 1ns / 1ps

module flood_fill_4conn import ffill_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // command items
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,  // x_coord[7:0], y_coord[15:8], pixel_color[31:16]
    input  logic [1:0]               s_tuser,  // opcode[1:0]
    // result items
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [39:0]              m_tdata,  // read_color[15:0], filled_count[32:16], zero
    output logic                     m_tuser   // coord_error[0]
);

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam int QW   = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

    size_cfg_t             sizes;
    logic [PIXEL_BITS-1:0] read_color;
    logic [COUNT_BITS-1:0] filled_count;
    logic                  coord_error;
    logic                  pix_wr_en;
    logic [AW-1:0]         pix_wr_addr;
    logic [COLOR_BITS-1:0] pix_wr_data;
    logic [AW-1:0]         pix_rd_addr;
    logic [COLOR_BITS-1:0] pix_rd_data;
    logic                  q_wr_en;
    logic [AW-1:0]         q_wr_addr;
    logic [QW-1:0]         q_wr_data;
    logic [AW-1:0]         q_rd_addr;
    logic [QW-1:0]         q_rd_data;

    // size registers
    ffill_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sizes   (sizes)
    );

    // command sequencer
    ffill_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sizes        (sizes),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .opcode       (s_tuser),
        .x_coord      (s_tdata[7:0]),
        .y_coord      (s_tdata[15:8]),
        .pixel_color  (s_tdata[31:16]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .read_color   (read_color),
        .filled_count (filled_count),
        .coord_error  (coord_error),
        .pix_wr_en    (pix_wr_en),
        .pix_wr_addr  (pix_wr_addr),
        .pix_wr_data  (pix_wr_data),
        .pix_rd_addr  (pix_rd_addr),
        .pix_rd_data  (pix_rd_data),
        .q_wr_en      (q_wr_en),
        .q_wr_addr    (q_wr_addr),
        .q_wr_data    (q_wr_data),
        .q_rd_addr    (q_rd_addr),
        .q_rd_data    (q_rd_data)
    );

    // pixel store
    ffill_ram #(
        .DATA_BITS (COLOR_BITS),
        .DEPTH     (NPIX)
    ) u_pix_ram (
        .aclk    (aclk),
        .wr_en   (pix_wr_en),
        .wr_addr (pix_wr_addr),
        .wr_data (pix_wr_data),
        .rd_addr (pix_rd_addr),
        .rd_data (pix_rd_data)
    );

    // breadth-first coordinate queue
    ffill_ram #(
        .DATA_BITS (QW),
        .DEPTH     (NPIX)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    // result packing
    assign m_tdata = {7'b0, filled_count, read_color};
    assign m_tuser = coord_error;

endmodule
